// ===== src/fdcr_pkg.sv =====
// Shared constants and codes for the floppy controller register block.
package fdcr_pkg;

    localparam int DEF_MAX_SECTORS       = 2048;
    localparam int DEF_SECTOR_BYTES      = 512;
    localparam int DEF_SECTORS_PER_TRACK = 9;

    localparam int IN_TDATA_W  = 32;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = 24;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 12;
    localparam int TRACKS      = 80;
    localparam int DM_WORD     = 32;

    // func codes
    localparam logic [2:0] F_BUS_RD   = 3'd0;
    localparam logic [2:0] F_BUS_WR   = 3'd1;
    localparam logic [2:0] F_IMG_LOAD = 3'd2;
    localparam logic [2:0] F_IMG_READ = 3'd3;
    localparam logic [2:0] F_TAKE_DTY = 3'd4;

    // bus register indexes
    localparam logic [2:0] R_CMD    = 3'd0;
    localparam logic [2:0] R_TRACK  = 3'd1;
    localparam logic [2:0] R_SECTOR = 3'd2;
    localparam logic [2:0] R_DATA   = 3'd3;
    localparam logic [2:0] R_SIDE   = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISK    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ISECT   = 2'd2;

    // command high nibbles
    localparam logic [3:0] C_RESTORE = 4'h0;
    localparam logic [3:0] C_SEEK    = 4'h1;
    localparam logic [3:0] C_STEPIN0 = 4'h4;
    localparam logic [3:0] C_STEPIN1 = 4'h5;
    localparam logic [3:0] C_STEPOT0 = 4'h6;
    localparam logic [3:0] C_STEPOT1 = 4'h7;
    localparam logic [3:0] C_RDSEC0  = 4'h8;
    localparam logic [3:0] C_RDSEC1  = 4'h9;
    localparam logic [3:0] C_WRSEC0  = 4'hA;
    localparam logic [3:0] C_WRSEC1  = 4'hB;
    localparam logic [3:0] C_RDADDR  = 4'hC;
    localparam logic [3:0] C_FORCEI  = 4'hD;

    // status and interface values
    localparam logic [7:0] ST_TRK0    = 8'h04;
    localparam logic [7:0] ST_RNF     = 8'h10;
    localparam logic [7:0] ST_BSYDRQ  = 8'h03;
    localparam logic [7:0] IF_SETTLE  = 8'hC0;
    localparam logic [7:0] IF_XFER    = 8'h40;
    localparam logic [7:0] ID_SIZE    = 8'h02;
    localparam logic [7:0] RD_NODEV   = 8'hFF;
    localparam logic [2:0] SETTLE_LEN = 3'd4;

    // transfer modes
    localparam logic [1:0] XM_IDLE  = 2'd0;
    localparam logic [1:0] XM_READ  = 2'd1;
    localparam logic [1:0] XM_WRITE = 2'd2;

endpackage

// ===== src/fdcr_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
module fdcr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== src/floppy_controller_registers.sv =====
// Read sector copies a sector image->buffer, write commit copies back and
// marks the dirty map, one byte at a time through the single RAM ports.
// Take dirty scans the dirty map one 32-bit row at a time.
// One request at a time; a waiting result does not block the next accept.
// Reset (sync, active low) clears control state, then a pass over all
// ceil(MAX_SECTORS/32) dirty-map rows zeroes it before requests are taken.
module floppy_controller_registers #(
    parameter int MAX_SECTORS       = fdcr_pkg::DEF_MAX_SECTORS,
    parameter int SECTOR_BYTES      = fdcr_pkg::DEF_SECTOR_BYTES,
    parameter int SECTORS_PER_TRACK = fdcr_pkg::DEF_SECTORS_PER_TRACK
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [fdcr_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [fdcr_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // reg_req[2:0], wdata[10:3], image_addr[30:11], zero pad
    input  logic [fdcr_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // func[2:0]
    input  logic [fdcr_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // rdata[7:0], dirty_valid[8], dirty_sector[19:9], any_dirty[20], zero pad
    output logic [fdcr_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
    import fdcr_pkg::*;

    localparam int unsigned MEM_BYTES = MAX_SECTORS * SECTOR_BYTES;
    localparam int IAW  = $clog2(MEM_BYTES);
    localparam int CMPW = (IAW + 1 > 21) ? IAW + 1 : 21;
    localparam int BW   = $clog2(SECTOR_BYTES);
    localparam int XW   = $clog2(SECTOR_BYTES + 1);
    localparam int SW   = $clog2(MAX_SECTORS);
    localparam int DR   = (MAX_SECTORS + DM_WORD - 1) / DM_WORD;
    localparam int RW   = $clog2(DR);
    localparam int NW   = 16;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_LOC, S_BASE, S_COPY, S_RDADDR, S_DRD, S_IMRD,
        S_CMB, S_CMC, S_DMR, S_DMW, S_DRQ, S_DCHK, S_FIN
    } t_state;

    t_state r_state;

    logic              r_enabled, r_disk;
    logic [11:0]       r_isect;
    logic [7:0]        r_status, r_track, r_sector, r_data, r_tmp_sec;
    logic              r_side, r_is_wr, r_dirty_flag, r_wv;
    logic [XW-1:0]     r_xfer_index, r_xfer_length, r_cnt;
    logic [1:0]        r_xfer_mode;
    logic [2:0]        r_settle;
    logic [SW-1:0]     r_target, r_lin;
    logic [IAW-1:0]    r_base;
    logic [BW-1:0]     r_wa;
    logic [RW:0]       r_dw;
    logic [RW-1:0]     r_clr;
    logic [7:0]        r_pr_rdata;
    logic              r_pr_valid;
    logic [SW-1:0]     r_pr_sec;
    logic              r_out_valid;
    logic [7:0]        r_out_rdata;
    logic              r_out_dv, r_out_any;
    logic [10:0]       r_out_sec;

    logic [2:0]        s_func, s_reg;
    logic [7:0]        s_wdata;
    logic [19:0]       s_addr;
    logic              acc, addr_ok;
    logic [NW-1:0]     n_usable, lin_sum, w32;
    logic              sides2, loc_ok;
    logic [8:0]        trk_side;
    logic [7:0]        t1_trk, ra_byte;
    logic [RW-1:0]     trow;

    logic              img_we;
    logic [IAW-1:0]    img_waddr, img_raddr;
    logic [7:0]        img_wdata, img_rdata;
    logic              buf_we;
    logic [BW-1:0]     buf_waddr, buf_raddr;
    logic [7:0]        buf_wdata, buf_rdata;
    logic              dm_we;
    logic [RW-1:0]     dm_waddr, dm_raddr;
    logic [DM_WORD-1:0] dm_wdata, dm_rdata, dm_mask, dm_hit;
    logic [4:0]        dm_rem, dm_pos;
    logic              dm_full, dm_found;

    assign s_func  = s_axis_tuser;
    assign s_reg   = s_axis_tdata[2:0];
    assign s_wdata = s_axis_tdata[10:3];
    assign s_addr  = s_axis_tdata[30:11];
    assign s_axis_tready = (r_state == S_IDLE);
    assign acc     = s_axis_tvalid && s_axis_tready;
    assign addr_ok = CMPW'(s_addr) < CMPW'(MEM_BYTES);

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out_any, r_out_sec, r_out_dv, r_out_rdata};

    // usable sector count and linear sector of the head position
    assign n_usable = (NW'(r_isect) > NW'(MAX_SECTORS)) ? NW'(MAX_SECTORS) : NW'(r_isect);
    assign sides2   = NW'(r_isect) > NW'(TRACKS * SECTORS_PER_TRACK);
    assign trk_side = sides2 ? {r_track, r_side} : {1'b0, r_track} + {8'd0, r_side};
    assign lin_sum  = NW'(trk_side) * NW'(SECTORS_PER_TRACK) + NW'(r_sector) - NW'(1);
    assign loc_ok   = r_disk && (r_sector != 8'd0) && (lin_sum < n_usable);
    assign trow     = RW'(r_target >> 5);

    always_comb begin
        case (s_wdata[7:4])
            C_RESTORE:            t1_trk = 8'd0;
            C_SEEK:               t1_trk = r_data;
            C_STEPIN0, C_STEPIN1: t1_trk = r_track + 8'd1;
            C_STEPOT0, C_STEPOT1: t1_trk = (r_track != 8'd0) ? r_track - 8'd1 : r_track;
            default:              t1_trk = r_track;
        endcase
    end

    always_comb begin
        case (r_cnt)
            XW'(0):  ra_byte = r_track;
            XW'(1):  ra_byte = {7'd0, r_side};
            XW'(2):  ra_byte = r_tmp_sec;
            XW'(3):  ra_byte = ID_SIZE;
            default: ra_byte = 8'd0;
        endcase
    end

    // dirty row: keep only sectors below the usable count, find lowest set bit
    always_comb begin
        w32     = NW'({r_dw, 5'b00000});
        dm_full = (w32 + NW'(DM_WORD)) <= n_usable;
        dm_rem  = 5'(n_usable - w32);
        dm_mask = dm_full ? '1 : ((DM_WORD'(1) << dm_rem) - DM_WORD'(1));
        dm_hit  = dm_rdata & dm_mask;
        dm_found = |dm_hit;
        dm_pos  = 5'd0;
        for (int b = DM_WORD - 1; b >= 0; b--) begin
            if (dm_hit[b]) dm_pos = 5'(b);
        end
    end

    always_comb begin
        img_raddr = (r_state == S_COPY) ? r_base + IAW'(r_cnt[BW-1:0]) : IAW'(s_addr);
        img_we    = (acc && s_func == F_IMG_LOAD && addr_ok) || (r_state == S_CMC && r_wv);
        img_waddr = (r_state == S_CMC) ? r_base + IAW'(r_wa) : IAW'(s_addr);
        img_wdata = (r_state == S_CMC) ? buf_rdata : s_wdata;

        buf_raddr = (r_state == S_CMC) ? r_cnt[BW-1:0] : r_xfer_index[BW-1:0];
        buf_we    = (acc && s_func == F_BUS_WR && r_enabled && s_reg == R_DATA
                     && r_xfer_mode == XM_WRITE)
                    || (r_state == S_COPY && r_wv) || (r_state == S_RDADDR);
        case (r_state)
            S_COPY:   begin buf_waddr = r_wa;              buf_wdata = img_rdata; end
            S_RDADDR: begin buf_waddr = BW'(r_cnt);        buf_wdata = ra_byte;   end
            default:  begin buf_waddr = r_xfer_index[BW-1:0]; buf_wdata = s_wdata; end
        endcase

        dm_raddr = (r_state == S_DRQ) ? r_dw[RW-1:0] : trow;
        dm_we    = (r_state == S_CLEAR) || (r_state == S_DCHK && dm_found) || (r_state == S_DMW);
        case (r_state)
            S_CLEAR: begin dm_waddr = r_clr;        dm_wdata = '0; end
            S_DCHK:  begin
                dm_waddr = r_dw[RW-1:0];
                dm_wdata = dm_rdata & ~(DM_WORD'(1) << dm_pos);
            end
            default: begin
                dm_waddr = trow;
                dm_wdata = dm_rdata | (DM_WORD'(1) << r_target[4:0]);
            end
        endcase
    end

    fdcr_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_img (
        .i_clk(i_clk), .i_we(img_we), .i_waddr(img_waddr), .i_wdata(img_wdata),
        .i_raddr(img_raddr), .o_rdata(img_rdata)
    );

    fdcr_ram #(.WIDTH(8), .DEPTH(SECTOR_BYTES)) u_buf (
        .i_clk(i_clk), .i_we(buf_we), .i_waddr(buf_waddr), .i_wdata(buf_wdata),
        .i_raddr(buf_raddr), .o_rdata(buf_rdata)
    );

    fdcr_ram #(.WIDTH(DM_WORD), .DEPTH(DR)) u_dmap (
        .i_clk(i_clk), .i_we(dm_we), .i_waddr(dm_waddr), .i_wdata(dm_wdata),
        .i_raddr(dm_raddr), .o_rdata(dm_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_enabled     <= 1'b0;
            r_disk        <= 1'b0;
            r_isect       <= '0;
            r_status      <= '0;
            r_track       <= '0;
            r_sector      <= '0;
            r_data        <= '0;
            r_side        <= 1'b0;
            r_xfer_index  <= '0;
            r_xfer_length <= '0;
            r_xfer_mode   <= XM_IDLE;
            r_settle      <= '0;
            r_target      <= '0;
            r_dirty_flag  <= 1'b0;
            r_clr         <= '0;
            r_wv          <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ENABLED: r_enabled <= i_cfg_wdata[0];
                    CFG_DISK:    r_disk    <= i_cfg_wdata[0];
                    CFG_ISECT:   r_isect   <= i_cfg_wdata;
                    default:     ;
                endcase
            end
            if (r_out_valid && m_axis_tready && r_state != S_FIN) r_out_valid <= 1'b0;

            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + RW'(1);
                    if (r_clr == RW'(DR - 1)) r_state <= S_IDLE;
                end
                S_IDLE: if (acc) begin
                    r_pr_rdata <= 8'd0;
                    r_pr_valid <= 1'b0;
                    r_pr_sec   <= '0;
                    r_state    <= S_FIN;
                    case (s_func)
                        F_BUS_RD: begin
                            if (!r_enabled) begin
                                r_pr_rdata <= RD_NODEV;
                            end else begin
                                case (s_reg)
                                    R_CMD:    r_pr_rdata <= r_status;
                                    R_TRACK:  r_pr_rdata <= r_track;
                                    R_SECTOR: r_pr_rdata <= r_sector;
                                    R_DATA: begin
                                        if (r_xfer_mode == XM_READ) r_state <= S_DRD;
                                        else r_pr_rdata <= r_data;
                                    end
                                    default: begin
                                        if (r_xfer_mode == XM_READ || r_xfer_mode == XM_WRITE) begin
                                            r_pr_rdata <= IF_XFER;
                                        end else if (r_settle != 3'd0) begin
                                            r_settle   <= r_settle - 3'd1;
                                            r_pr_rdata <= IF_SETTLE;
                                        end
                                    end
                                endcase
                            end
                        end
                        F_BUS_WR: if (r_enabled) begin
                            case (s_reg)
                                R_CMD: begin
                                    if (s_wdata[7:4] == C_FORCEI) begin
                                        r_status    <= r_status & ~ST_BSYDRQ;
                                        r_xfer_mode <= XM_IDLE;
                                    end else if (!s_wdata[7]) begin
                                        r_track  <= t1_trk;
                                        r_status <= (t1_trk == 8'd0) ? ST_TRK0 : 8'd0;
                                        r_settle <= SETTLE_LEN;
                                    end else begin
                                        case (s_wdata[7:4])
                                            C_RDSEC0, C_RDSEC1, C_WRSEC0, C_WRSEC1: begin
                                                r_is_wr <= s_wdata[5];
                                                r_state <= S_LOC;
                                            end
                                            C_RDADDR: begin
                                                r_tmp_sec <= (r_sector == 8'd0) ? 8'd1 : r_sector;
                                                r_cnt     <= '0;
                                                r_state   <= S_RDADDR;
                                            end
                                            default: begin
                                                r_status    <= 8'd0;
                                                r_xfer_mode <= XM_IDLE;
                                            end
                                        endcase
                                    end
                                end
                                R_TRACK:  r_track  <= s_wdata;
                                R_SECTOR: r_sector <= s_wdata;
                                R_DATA: begin
                                    r_data <= s_wdata;
                                    if (r_xfer_mode == XM_WRITE) begin
                                        r_xfer_index <= r_xfer_index + XW'(1);
                                        if (r_xfer_index + XW'(1) >= r_xfer_length)
                                            r_state <= S_CMB;
                                    end
                                end
                                R_SIDE:   r_side <= s_wdata[0];
                                default:  ;
                            endcase
                        end
                        F_IMG_READ: if (addr_ok) r_state <= S_IMRD;
                        F_TAKE_DTY: begin
                            if (r_disk) begin
                                r_dw    <= '0;
                                r_state <= S_DRQ;
                            end else begin
                                r_dirty_flag <= 1'b0;
                            end
                        end
                        default: ;
                    endcase
                end
                S_LOC: begin
                    r_lin <= lin_sum[SW-1:0];
                    if (loc_ok) begin
                        r_state <= S_BASE;
                    end else begin
                        r_status    <= ST_RNF;
                        r_xfer_mode <= XM_IDLE;
                        r_state     <= S_FIN;
                    end
                end
                S_BASE: begin
                    r_base <= IAW'(IAW'(r_lin) * IAW'(SECTOR_BYTES));
                    r_cnt  <= '0;
                    r_wv   <= 1'b0;
                    if (r_is_wr) begin
                        r_target      <= r_lin;
                        r_xfer_mode   <= XM_WRITE;
                        r_xfer_index  <= '0;
                        r_xfer_length <= XW'(SECTOR_BYTES);
                        r_status      <= ST_BSYDRQ;
                        r_state       <= S_FIN;
                    end else begin
                        r_state <= S_COPY;
                    end
                end
                S_COPY, S_CMC: begin
                    if (r_cnt < XW'(SECTOR_BYTES)) begin
                        r_cnt <= r_cnt + XW'(1);
                        r_wv  <= 1'b1;
                        r_wa  <= r_cnt[BW-1:0];
                    end else begin
                        r_wv <= 1'b0;
                        if (r_state == S_COPY) begin
                            r_xfer_mode   <= XM_READ;
                            r_xfer_index  <= '0;
                            r_xfer_length <= XW'(SECTOR_BYTES);
                            r_status      <= ST_BSYDRQ;
                            r_state       <= S_FIN;
                        end else begin
                            r_state <= S_DMR;
                        end
                    end
                end
                S_RDADDR: begin
                    r_cnt <= r_cnt + XW'(1);
                    if (r_cnt == XW'(5)) begin
                        r_sector      <= r_track;
                        r_xfer_index  <= '0;
                        r_xfer_length <= XW'(6);
                        r_xfer_mode   <= XM_READ;
                        r_status      <= ST_BSYDRQ;
                        r_state       <= S_FIN;
                    end
                end
                S_DRD: begin
                    r_pr_rdata   <= buf_rdata;
                    r_xfer_index <= r_xfer_index + XW'(1);
                    if (r_xfer_index + XW'(1) >= r_xfer_length) begin
                        r_status    <= 8'd0;
                        r_xfer_mode <= XM_IDLE;
                    end
                    r_state <= S_FIN;
                end
                S_IMRD: begin
                    r_pr_rdata <= img_rdata;
                    r_state    <= S_FIN;
                end
                S_CMB: begin
                    r_base <= IAW'(IAW'(r_target) * IAW'(SECTOR_BYTES));
                    r_cnt  <= '0;
                    r_wv   <= 1'b0;
                    if (r_disk && NW'(r_target) < n_usable) begin
                        r_state <= S_CMC;
                    end else begin
                        r_status    <= 8'd0;
                        r_xfer_mode <= XM_IDLE;
                        r_state     <= S_FIN;
                    end
                end
                S_DMR: r_state <= S_DMW;
                S_DMW: begin
                    r_dirty_flag <= 1'b1;
                    r_status     <= 8'd0;
                    r_xfer_mode  <= XM_IDLE;
                    r_state      <= S_FIN;
                end
                S_DRQ: begin
                    if (w32 < n_usable) begin
                        r_state <= S_DCHK;
                    end else begin
                        r_dirty_flag <= 1'b0;
                        r_state      <= S_FIN;
                    end
                end
                S_DCHK: begin
                    if (dm_found) begin
                        r_pr_valid <= 1'b1;
                        r_pr_sec   <= SW'({r_dw[RW-1:0], dm_pos});
                        r_state    <= S_FIN;
                    end else begin
                        r_dw    <= r_dw + (RW + 1)'(1);
                        r_state <= S_DRQ;
                    end
                end
                S_FIN: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_rdata <= r_pr_rdata;
                        r_out_dv    <= r_pr_valid;
                        r_out_sec   <= 11'(r_pr_sec);
                        r_out_any   <= r_dirty_flag;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_acc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> (r_state != S_IDLE))
        else $error("accepted request did not leave idle");

    // a finished write sits at index == length until the commit clears the mode
    a_idx_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_xfer_mode != XM_IDLE) |-> (r_xfer_index < r_xfer_length))
        else $error("transfer index reached length while active");

    a_wr_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_xfer_mode == XM_WRITE) |-> (r_xfer_length == XW'(SECTOR_BYTES)))
        else $error("write transfer length not a full sector");

    a_dv_sec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_dv) |-> (r_out_sec == 11'd0))
        else $error("dirty sector nonzero without a dirty sector found");
endmodule
